>>> src/vwam_pkg.sv
// ============================================================================
// vwam_pkg
// Shared widths, register indexes and types of the video window mask core.
// ============================================================================
package vwam_pkg;

  // Field and register widths
  localparam int unsigned START_W = 20;
  localparam int unsigned TPF_W   = 16;
  localparam int unsigned FRAME_W = 13;
  localparam int unsigned MODE_W  = 2;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 20;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_SPAN_BASE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_TOKENS  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FRAME_COUNT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_WINDOW_RADIUS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FRAME_CHUNK   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ANCHOR_MODE   = 3'd5;

  // Anchor mode bits
  localparam int unsigned ANCHOR_KEY_BIT   = 0;
  localparam int unsigned ANCHOR_QUERY_BIT = 1;

  // Datapath widths
  localparam int unsigned PROD_W  = FRAME_W + TPF_W;     // frames * tokens
  localparam int unsigned WIN_W   = FRAME_W + 2;         // signed group bound
  localparam int unsigned BOUND_W = WIN_W + FRAME_W + 1; // signed frame bound

  // Pipeline depth in registers, input capture to result
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned BACK_STAGES  = 3;
  localparam int unsigned LATENCY      = FRONT_STAGES + 2 * FRAME_W + BACK_STAGES;

  typedef struct packed {
    logic [START_W-1:0] span_base;
    logic [TPF_W-1:0]   frame_tokens;
    logic [FRAME_W-1:0] frame_count;
    logic [FRAME_W-1:0] window_radius;
    logic [FRAME_W-1:0] frame_chunk;
    logic [MODE_W-1:0]  anchor_mode;
  } cfg_t;

  // Per-word info carried alongside the group divider
  typedef struct packed {
    logic               in_span;
    logic [FRAME_W-1:0] qf;
    logic [FRAME_W-1:0] kf;
  } win_item_t;

endpackage

>>> src/video_window_attention_mask_core.sv
// Result: allowed_o is driven with done_o for one cycle, once the word taken
// with start_i has passed through all pipeline registers
// (3 front stages, 13 + 13 divider stages, 3 back).
// Throughput: one word per cycle; the two pipelined dividers set the depth.
// busy_o stays low, the receiver cannot stall, so nothing ever backs up.
// Reset clears all valid bits and the configuration registers to zero.
// ============================================================================
// video_window_attention_mask_core
// Sliding-window attention mask for video token spans: per query/key pair
// decides whether attention is allowed.
// ============================================================================
module video_window_attention_mask_core
  import vwam_pkg::*;
#(
  parameter int unsigned ROW_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [ROW_BITS-1:0] query_index_i,
  input  logic [ROW_BITS-1:0] key_index_i,
  output logic                done_o,
  output logic                allowed_o,
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_addr_i,
  input  logic [CFG_DW-1:0]   cfg_wdata_i
);

  localparam int unsigned DW = (ROW_BITS > START_W) ? ROW_BITS : START_W;
  localparam int unsigned CW = (DW > PROD_W) ? DW : PROD_W;

  // ---------------- configuration registers
  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SPAN_BASE:     cfg_d.span_base     = cfg_wdata_i[START_W-1:0];
        REG_FRAME_TOKENS:  cfg_d.frame_tokens  = cfg_wdata_i[TPF_W-1:0];
        REG_FRAME_COUNT:   cfg_d.frame_count   = cfg_wdata_i[FRAME_W-1:0];
        REG_WINDOW_RADIUS: cfg_d.window_radius = cfg_wdata_i[FRAME_W-1:0];
        REG_FRAME_CHUNK:   cfg_d.frame_chunk   = cfg_wdata_i[FRAME_W-1:0];
        REG_ANCHOR_MODE:   cfg_d.anchor_mode   = cfg_wdata_i[MODE_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- input capture
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic                vld1_q;
  logic [ROW_BITS-1:0] q1_q, k1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q1_q <= query_index_i;
      k1_q <= key_index_i;
    end
  end

  // ---------------- offsets from span start, span length
  logic [DW:0]         dq_diff, dk_diff;
  logic [PROD_W-1:0]   prod_d;

  assign dq_diff = {1'b0, DW'(q1_q)} - {1'b0, DW'(cfg_q.span_base)};
  assign dk_diff = {1'b0, DW'(k1_q)} - {1'b0, DW'(cfg_q.span_base)};
  assign prod_d  = PROD_W'(cfg_q.frame_count) * PROD_W'(cfg_q.frame_tokens);

  logic              vld2_q;
  logic              qlow2_q, klow2_q;
  logic [DW-1:0]     dq2_q, dk2_q;
  logic [PROD_W-1:0] prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      qlow2_q <= dq_diff[DW];
      klow2_q <= dk_diff[DW];
      dq2_q   <= dq_diff[DW-1:0];
      dk2_q   <= dk_diff[DW-1:0];
      prod2_q <= prod_d;
    end
  end

  // ---------------- span test; empty span never matches
  logic in_span_d;

  assign in_span_d = !qlow2_q && (CW'(dq2_q) < CW'(prod2_q))
                  && !klow2_q && (CW'(dk2_q) < CW'(prod2_q));

  logic          vld3_q;
  logic          span3_q;
  logic [DW-1:0] dq3_q, dk3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld2_q) begin
      span3_q <= in_span_d;
      dq3_q   <= dq2_q;
      dk3_q   <= dk2_q;
    end
  end

  // ---------------- frame index of query and key
  logic [1:0][DW-1:0]      frame_dvd;
  logic [1:0][FRAME_W-1:0] frame_quo;
  logic                    frame_vld;
  logic                    frame_span;

  assign frame_dvd[0] = dq3_q;
  assign frame_dvd[1] = dk3_q;

  vwam_div #(
    .LANES (2),
    .DW    (DW),
    .QW    (FRAME_W),
    .VW    (TPF_W),
    .SW    (1)
  ) u_frame_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld3_q),
    .dividend_i (frame_dvd),
    .divisor_i  (cfg_q.frame_tokens),
    .side_i     (span3_q),
    .valid_o    (frame_vld),
    .quotient_o (frame_quo),
    .side_o     (frame_span)
  );

  // ---------------- chunk group of the query frame
  win_item_t               grp_item_in, grp_item_out;
  logic [0:0][FRAME_W-1:0] grp_dvd;
  logic [0:0][FRAME_W-1:0] grp_quo;
  logic                    grp_vld;

  assign grp_item_in.in_span = frame_span;
  assign grp_item_in.qf      = frame_quo[0];
  assign grp_item_in.kf      = frame_quo[1];
  assign grp_dvd[0]          = frame_quo[0];

  vwam_div #(
    .LANES (1),
    .DW    (FRAME_W),
    .QW    (FRAME_W),
    .VW    (FRAME_W),
    .SW    ($bits(win_item_t))
  ) u_group_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (frame_vld),
    .dividend_i (grp_dvd),
    .divisor_i  (cfg_q.frame_chunk),
    .side_i     (grp_item_in),
    .valid_o    (grp_vld),
    .quotient_o (grp_quo),
    .side_o     (grp_item_out)
  );

  // ---------------- window and anchor decision
  vwam_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (grp_vld),
    .item_i    (grp_item_out),
    .group_i   (grp_quo[0]),
    .cfg_i     (cfg_q),
    .done_o    (done_o),
    .allowed_o (allowed_o)
  );

endmodule

>>> src/vwam_div.sv
// ============================================================================
// vwam_div
// Pipelined restoring divider: one quotient bit per stage, shared divisor,
// one or more dividend lanes and a sideband that rides with the valid bit.
// ============================================================================
module vwam_div #(
  parameter int unsigned LANES = 2,
  parameter int unsigned DW    = 20,
  parameter int unsigned QW    = 13,
  parameter int unsigned VW    = 16,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [LANES-1:0][DW-1:0]   dividend_i,
  input  logic [VW-1:0]              divisor_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quotient_o,
  output logic [SW-1:0]              side_o
);

  // Quotient must fit in QW bits: dividend < divisor << QW
  localparam int unsigned EW = DW + QW;

  logic                     vld_q  [QW];
  logic [LANES-1:0][DW-1:0] rem_q  [QW-1];
  logic [LANES-1:0][QW-1:0] quo_q  [QW];
  logic [SW-1:0]            side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Shift = QW - 1 - s;

    logic                     vld_in;
    logic [LANES-1:0][DW-1:0] rem_in;
    logic [LANES-1:0][QW-1:0] quo_in;
    logic [SW-1:0]            side_in;
    logic [EW-1:0]            step;
    logic [LANES-1:0]         fits;

    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = dividend_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_tail
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Trial subtract of divisor at this bit weight
    assign step = EW'(divisor_i) << Shift;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        fits[l] = EW'(rem_in[l]) >= step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        side_q[s] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          quo_q[s][l] <= {quo_in[l][QW-2:0], fits[l]};
        end
      end
    end

    // Remainder goes on to the next stage only
    if (s < QW - 1) begin : g_rem
      logic [LANES-1:0][EW-1:0] diff;

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          diff[l] = EW'(rem_in[l]) - step;
        end
      end

      always_ff @(posedge clk_i) begin
        if (vld_in) begin
          for (int l = 0; l < LANES; l++) begin
            rem_q[s][l] <= fits[l] ? diff[l][DW-1:0] : rem_in[l];
          end
        end
      end
    end
  end

  assign valid_o    = vld_q[QW-1];
  assign quotient_o = quo_q[QW-1];
  assign side_o     = side_q[QW-1];

endmodule

>>> src/vwam_window.sv
// ============================================================================
// vwam_window
// Window bounds, anchor checks and the final allow decision (three stages).
// ============================================================================
module vwam_window
  import vwam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  win_item_t          item_i,
  input  logic [FRAME_W-1:0] group_i,
  input  cfg_t               cfg_i,
  output logic               done_o,
  output logic               allowed_o
);

  // ---------------- stage A: group select, unscaled bounds, anchors
  logic               chunked;
  logic [FRAME_W-1:0] gsel;
  logic [FRAME_W-1:0] csel;
  logic [FRAME_W-1:0] last_frame;
  logic signed [WIN_W-1:0] lo_f_d, hi_f_d;
  logic               key_anc_d, qry_anc_d;

  assign chunked    = cfg_i.frame_chunk != '0;
  assign gsel       = chunked ? group_i : item_i.qf;
  assign csel       = chunked ? cfg_i.frame_chunk : FRAME_W'(1);
  assign last_frame = cfg_i.frame_count - FRAME_W'(1);

  // lo = g - r, exclusive hi = g + r + 1, both in groups
  assign lo_f_d = $signed(WIN_W'(gsel)) - $signed(WIN_W'(cfg_i.window_radius));
  assign hi_f_d = $signed(WIN_W'(gsel)) + $signed(WIN_W'(cfg_i.window_radius))
                + $signed(WIN_W'(1));

  assign key_anc_d = (item_i.kf == '0) || (item_i.kf == last_frame);
  assign qry_anc_d = (item_i.qf == '0) || (item_i.qf == last_frame);

  logic                    vld_a_q;
  logic                    span_a_q;
  logic [FRAME_W-1:0]      kf_a_q;
  logic [FRAME_W-1:0]      csel_a_q;
  logic signed [WIN_W-1:0] lo_f_q, hi_f_q;
  logic                    key_anc_a_q, qry_anc_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      span_a_q    <= item_i.in_span;
      kf_a_q      <= item_i.kf;
      csel_a_q    <= csel;
      lo_f_q      <= lo_f_d;
      hi_f_q      <= hi_f_d;
      key_anc_a_q <= key_anc_d;
      qry_anc_a_q <= qry_anc_d;
    end
  end

  // ---------------- stage B: scale bounds to frames
  logic signed [BOUND_W-1:0] lo_d, hi_d;

  assign lo_d = BOUND_W'(lo_f_q) * $signed(BOUND_W'(csel_a_q));
  assign hi_d = BOUND_W'(hi_f_q) * $signed(BOUND_W'(csel_a_q));

  logic                      vld_b_q;
  logic                      span_b_q;
  logic [FRAME_W-1:0]        kf_b_q;
  logic signed [BOUND_W-1:0] lo_q, hi_q;
  logic                      key_anc_b_q, qry_anc_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_a_q) begin
      span_b_q    <= span_a_q;
      kf_b_q      <= kf_a_q;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      key_anc_b_q <= key_anc_a_q;
      qry_anc_b_q <= qry_anc_a_q;
    end
  end

  // ---------------- stage C: window test and anchors
  logic signed [BOUND_W-1:0] kf_ext;
  logic                      in_win;
  logic                      allowed_d;

  assign kf_ext    = $signed(BOUND_W'(kf_b_q));
  assign in_win    = (kf_ext >= lo_q) && (kf_ext < hi_q);
  assign allowed_d = !span_b_q || in_win
                  || (cfg_i.anchor_mode[ANCHOR_KEY_BIT] && key_anc_b_q)
                  || (cfg_i.anchor_mode[ANCHOR_QUERY_BIT] && qry_anc_b_q);

  logic done_q;
  logic allowed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_b_q) begin
      allowed_q <= allowed_d;
    end
  end

  assign done_o    = done_q;
  assign allowed_o = allowed_q;

endmodule

>>> src/vwam_checker.sv
// ============================================================================
// vwam_checker
// Port-level checks of the video window mask core, bound to the top level.
// ============================================================================
module vwam_checker
  import vwam_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic              allowed_o,
  input logic              cfg_we_i,
  input logic [CFG_AW-1:0] cfg_addr_i,
  input logic [CFG_DW-1:0] cfg_wdata_i
);

  // Track whether the video span is empty from the config writes
  logic tpf_zero_q, frames_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpf_zero_q    <= 1'b1;
      frames_zero_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_FRAME_TOKENS) begin
        tpf_zero_q <= cfg_wdata_i[TPF_W-1:0] == '0;
      end
      if (cfg_addr_i == REG_FRAME_COUNT) begin
        frames_zero_q <= cfg_wdata_i[FRAME_W-1:0] == '0;
      end
    end
  end

  // Pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy_o raised");

  // Every result traces back to an accepted input word
  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching input word");

  // Result bit is always known
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(allowed_o))
    else $error("allowed_o unknown on result");

  // Empty span allows everything
  a_empty_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (tpf_zero_q || frames_zero_q)) |-> allowed_o)
    else $error("pair masked while span is empty");

endmodule

bind video_window_attention_mask_core vwam_checker u_vwam_checker (.*);
